// ===== design/aarm_pkg.sv =====
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types, constants and helpers of the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int TRIG_STEPS    = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_N      = (TRIG_STEPS < ATAN_ENTRIES) ? TRIG_STEPS : ATAN_ENTRIES;
    localparam int SQRT_STAGES   = 32;
    localparam int DIV_STAGES    = 31;
    localparam int NORM_LAT      = 1 + SQRT_STAGES + DIV_STAGES;
    localparam int TRIG_CORE_LAT = 2 + CORDIC_N;
    localparam int TRIG_PAD      = NORM_LAT - TRIG_CORE_LAT;

    localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic [41:0]        RAD_PER_CDEG = 42'd191900981;

    typedef logic signed [31:0] unit_t;
    typedef logic signed [32:0] trig_t;

    typedef struct packed {
        logic            zero;
        logic [2:0]      sgn;
        logic [2:0][15:0] mag;
    } side_t;

    function automatic trig_t atan_q30(input int i);
        trig_t r;
        case (i)
            0:  r = 33'sh03243F6A8;
            1:  r = 33'sh01DAC6705;
            2:  r = 33'sh00FADBAFC;
            3:  r = 33'sh007F56EA6;
            4:  r = 33'sh003FEAB76;
            5:  r = 33'sh001FFD55B;
            6:  r = 33'sh000FFFAAA;
            7:  r = 33'sh0007FFF55;
            8:  r = 33'sh0003FFFEA;
            9:  r = 33'sh0001FFFFD;
            10: r = 33'sh0000FFFFF;
            11: r = 33'sh00007FFFF;
            12: r = 33'sh00003FFFF;
            13: r = 33'sh00001FFFF;
            14: r = 33'sh00000FFFF;
            15: r = 33'sh000007FFF;
            16: r = 33'sh000003FFF;
            17: r = 33'sh000001FFF;
            18: r = 33'sh000000FFF;
            19: r = 33'sh0000007FF;
            20: r = 33'sh0000003FF;
            21: r = 33'sh0000001FF;
            22: r = 33'sh0000000FF;
            default: r = 33'sh00000007F;
        endcase
        return r;
    endfunction

    // Q2.30 product back to Q2.30, round half up
    function automatic logic signed [33:0] round30(input logic signed [63:0] p);
        logic signed [63:0] v;
        v = p + 64'sd536870912;
        return v[63:30];
    endfunction

endpackage

// ===== design/aarm_norm.sv =====
// ----------------------------------------------------------------------------
// aarm_norm
// Axis normalization: sum of squares, bit-per-stage square root, then three
// restoring dividers, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aarm_norm import aarm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic signed [15:0] az,
    output logic              vld,
    output logic              zero,
    output unit_t             ux,
    output unit_t             uy,
    output unit_t             uz
);

    logic signed [15:0] a [3];
    logic [31:0]        sq [3];
    side_t              side_next;
    logic [31:0]        n2_next;

    logic [31:0]        n2_reg;
    side_t              side_reg [0:NORM_LAT-1];
    logic [NORM_LAT-1:0] vld_reg;

    logic [63:0] sv_reg  [1:SQRT_STAGES];
    logic [63:0] sr_reg  [1:SQRT_STAGES];
    logic [63:0] sv_next [1:SQRT_STAGES];
    logic [63:0] sr_next [1:SQRT_STAGES];

    logic [63:0] dr_reg  [0:2][1:DIV_STAGES];
    logic [30:0] dq_reg  [0:2][1:DIV_STAGES];
    logic [63:0] dr_next [0:2][1:DIV_STAGES];
    logic [30:0] dq_next [0:2][1:DIV_STAGES];
    logic [31:0] dn_reg  [1:DIV_STAGES];
    logic [31:0] dn_next [1:DIV_STAGES];

    logic [31:0] norm;
    logic [63:0] num0 [3];
    unit_t       u [3];

    assign a[0] = ax;
    assign a[1] = ay;
    assign a[2] = az;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            sq[l]             = 32'(a[l] * a[l]);
            side_next.sgn[l]  = a[l][15];
            side_next.mag[l]  = a[l][15] ? 16'(-a[l]) : 16'(a[l]);
        end
        n2_next        = sq[0] + sq[1] + sq[2];
        side_next.zero = (n2_next == 32'd0);
    end

    // square root of n2 * 2^32, one result bit per stage
    for (genvar k = 1; k <= SQRT_STAGES; k++)
    begin : g_sqrt
        logic [63:0] v_in;
        logic [63:0] r_in;
        logic [63:0] bitv;
        logic [63:0] trial;
        if (k == 1)
        begin : g_first
            assign v_in = {n2_reg, 32'd0};
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = sv_reg[k-1];
            assign r_in = sr_reg[k-1];
        end
        assign bitv  = 64'd1 << (64 - 2 * k);
        assign trial = r_in + bitv;
        assign sv_next[k] = (v_in >= trial) ? (v_in - trial) : v_in;
        assign sr_next[k] = (v_in >= trial) ? ((r_in >> 1) + bitv) : (r_in >> 1);
    end

    assign norm = sr_reg[SQRT_STAGES][31:0];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            num0[l] = (64'(side_reg[SQRT_STAGES].mag[l]) << 46) + 64'(norm >> 1);
    end

    // quotient is known to stay below 2^31
    for (genvar j = 1; j <= DIV_STAGES; j++)
    begin : g_div
        localparam int B = DIV_STAGES - j;
        logic [31:0] n_in;
        if (j == 1)
        begin : g_first
            assign n_in = norm;
        end
        else
        begin : g_rest
            assign n_in = dn_reg[j-1];
        end
        assign dn_next[j] = n_in;
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [63:0] rem_in;
            logic [30:0] q_in;
            logic [63:0] d;
            if (j == 1)
            begin : g_first
                assign rem_in = num0[l];
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign rem_in = dr_reg[l][j-1];
                assign q_in   = dq_reg[l][j-1];
            end
            assign d = 64'(n_in) << B;
            assign dr_next[l][j] = (rem_in >= d) ? (rem_in - d) : rem_in;
            assign dq_next[l][j] = (rem_in >= d) ? (q_in | (31'd1 << B)) : q_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NORM_LAT-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg      <= n2_next;
            side_reg[0] <= side_next;
            for (int i = 1; i < NORM_LAT; i++)
                side_reg[i] <= side_reg[i-1];
            for (int k = 1; k <= SQRT_STAGES; k++)
            begin
                sv_reg[k] <= sv_next[k];
                sr_reg[k] <= sr_next[k];
            end
            for (int j = 1; j <= DIV_STAGES; j++)
            begin
                dn_reg[j] <= dn_next[j];
                for (int l = 0; l < 3; l++)
                begin
                    dr_reg[l][j] <= dr_next[l][j];
                    dq_reg[l][j] <= dq_next[l][j];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [30:0] qc;
            qc   = (dq_reg[l][DIV_STAGES] > 31'd1073741824) ? 31'd1073741824
                                                            : dq_reg[l][DIV_STAGES];
            u[l] = side_reg[NORM_LAT-1].sgn[l] ? -unit_t'(qc) : unit_t'(qc);
        end
    end

    assign ux   = u[0];
    assign uy   = u[1];
    assign uz   = u[2];
    assign vld  = vld_reg[NORM_LAT-1];
    assign zero = side_reg[NORM_LAT-1].zero;

endmodule

// ===== design/aarm_trig.sv =====
// ----------------------------------------------------------------------------
// aarm_trig
// Angle reduction to the first quadrant, radian scaling, pipelined CORDIC,
// then a delay line that lines cosine and sine up with the unit axis.
// ----------------------------------------------------------------------------
module aarm_trig import aarm_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic signed [16:0] angle,
    output trig_t              c,
    output trig_t              s
);

    logic signed [17:0] a18;
    logic signed [17:0] r1;
    logic signed [17:0] r2;
    logic [14:0]        mabs;
    logic [13:0]        m_next;
    logic [1:0]         fl_next;   // {cneg, sneg}
    logic [41:0]        prod;
    logic [41:0]        tr;

    logic [13:0] m_reg;
    logic [1:0]  fl_reg [0:CORDIC_N+1];
    trig_t       theta_reg;

    trig_t cx_reg  [1:CORDIC_N];
    trig_t cy_reg  [1:CORDIC_N];
    trig_t cz_reg  [1:CORDIC_N];
    trig_t cx_next [1:CORDIC_N];
    trig_t cy_next [1:CORDIC_N];
    trig_t cz_next [1:CORDIC_N];

    trig_t c_fin;
    trig_t s_fin;
    trig_t pc_reg [1:TRIG_PAD];
    trig_t ps_reg [1:TRIG_PAD];

    function automatic trig_t clamp30(input trig_t v);
        if (v > ONE_Q30)
            return ONE_Q30;
        if (v < -ONE_Q30)
            return -ONE_Q30;
        return v;
    endfunction

    always_comb
    begin
        a18 = 18'(angle);
        if (a18 < -18'sd36000)
            r1 = a18 + 18'sd72000;
        else if (a18 < 18'sd0)
            r1 = a18 + 18'sd36000;
        else if (a18 >= 18'sd36000)
            r1 = a18 - 18'sd36000;
        else
            r1 = a18;
        r2   = (r1 > 18'sd18000) ? (r1 - 18'sd36000) : r1;
        mabs = r2[17] ? 15'(-r2) : 15'(r2);
        fl_next[0] = r2[17];
        fl_next[1] = (mabs > 15'd9000);
        m_next     = (mabs > 15'd9000) ? 14'(15'd18000 - mabs) : 14'(mabs);
    end

    assign prod = 42'(m_reg) * RAD_PER_CDEG;
    assign tr   = prod + 42'd512;

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_cordic
        trig_t x_in;
        trig_t y_in;
        trig_t z_in;
        trig_t dx;
        trig_t dy;
        if (i == 0)
        begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = theta_reg;
        end
        else
        begin : g_rest
            assign x_in = cx_reg[i];
            assign y_in = cy_reg[i];
            assign z_in = cz_reg[i];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign cx_next[i+1] = z_in[32] ? (x_in + dx) : (x_in - dx);
        assign cy_next[i+1] = z_in[32] ? (y_in - dy) : (y_in + dy);
        assign cz_next[i+1] = z_in[32] ? (z_in + atan_q30(i)) : (z_in - atan_q30(i));
    end

    always_comb
    begin
        trig_t cc;
        trig_t sc;
        cc    = clamp30(cx_reg[CORDIC_N]);
        sc    = clamp30(cy_reg[CORDIC_N]);
        c_fin = fl_reg[CORDIC_N+1][1] ? -cc : cc;
        s_fin = fl_reg[CORDIC_N+1][0] ? -sc : sc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg     <= m_next;
            fl_reg[0] <= fl_next;
            for (int i = 1; i <= CORDIC_N + 1; i++)
                fl_reg[i] <= fl_reg[i-1];
            theta_reg <= {2'b00, tr[40:10]};
            for (int i = 1; i <= CORDIC_N; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            pc_reg[1] <= c_fin;
            ps_reg[1] <= s_fin;
            for (int i = 2; i <= TRIG_PAD; i++)
            begin
                pc_reg[i] <= pc_reg[i-1];
                ps_reg[i] <= ps_reg[i-1];
            end
        end
    end

    assign c = pc_reg[TRIG_PAD];
    assign s = ps_reg[TRIG_PAD];

endmodule

// ===== design/aarm_matrix.sv =====
// ----------------------------------------------------------------------------
// aarm_matrix
// Rodrigues entries: axis products and sine terms, scaling by 1 - c, then
// sums rounded and saturated to Q1.14 (identity for a zero axis) into the output register.
// ----------------------------------------------------------------------------
module aarm_matrix import aarm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic              in_zero,
    input  unit_t             ux,
    input  unit_t             uy,
    input  unit_t             uz,
    input  trig_t             c,
    input  trig_t             s,
    output logic              vld,
    output logic              zero,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);

    logic [2:0] vld_reg;
    logic [2:0] zero_reg;

    // first stage
    unit_t pxx_reg, pyy_reg, pzz_reg, pxy_reg, pxz_reg, pyz_reg;
    unit_t sx1_reg, sy1_reg, sz1_reg;
    trig_t c1_reg, t1_reg;
    // second stage
    trig_t dxx_reg, dyy_reg, dzz_reg, dxy_reg, dxz_reg, dyz_reg;
    unit_t sx2_reg, sy2_reg, sz2_reg;
    trig_t c2_reg;
    // output stage
    logic signed [15:0] m_reg [9];
    logic signed [15:0] m_next [9];

    function automatic unit_t mul_uu(input unit_t p, input unit_t q);
        logic signed [33:0] r;
        r = round30(64'(p) * 64'(q));
        return r[31:0];
    endfunction

    function automatic unit_t mul_ut(input unit_t p, input trig_t q);
        logic signed [33:0] r;
        r = round30(64'(p) * 64'(q));
        return r[31:0];
    endfunction

    function automatic trig_t mul_t(input unit_t p, input trig_t q);
        logic signed [33:0] r;
        r = round30(64'(p) * 64'(q));
        return r[32:0];
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [33:0] r;
        logic signed [17:0] h;
        r = v + 34'sd32768;
        h = r[33:16];
        if (h > 18'sd16384)
            return 16'sd16384;
        if (h < -18'sd16384)
            return -16'sd16384;
        return h[15:0];
    endfunction

    always_comb
    begin
        logic signed [33:0] sm [9];
        sm[0] = 34'(c2_reg) + 34'(dxx_reg);
        sm[1] = 34'(dxy_reg) + 34'(sz2_reg);
        sm[2] = 34'(dxz_reg) - 34'(sy2_reg);
        sm[3] = 34'(dxy_reg) - 34'(sz2_reg);
        sm[4] = 34'(c2_reg) + 34'(dyy_reg);
        sm[5] = 34'(dyz_reg) + 34'(sx2_reg);
        sm[6] = 34'(dxz_reg) + 34'(sy2_reg);
        sm[7] = 34'(dyz_reg) - 34'(sx2_reg);
        sm[8] = 34'(c2_reg) + 34'(dzz_reg);
        for (int e = 0; e < 9; e++)
        begin
            if (zero_reg[1])
                m_next[e] = (e % 4 == 0) ? 16'sd16384 : 16'sd0;
            else
                m_next[e] = to_q14(sm[e]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[1:0], in_zero};

            pxx_reg <= mul_uu(ux, ux);
            pyy_reg <= mul_uu(uy, uy);
            pzz_reg <= mul_uu(uz, uz);
            pxy_reg <= mul_uu(ux, uy);
            pxz_reg <= mul_uu(ux, uz);
            pyz_reg <= mul_uu(uy, uz);
            sx1_reg <= mul_ut(ux, s);
            sy1_reg <= mul_ut(uy, s);
            sz1_reg <= mul_ut(uz, s);
            c1_reg  <= c;
            t1_reg  <= ONE_Q30 - c;

            dxx_reg <= mul_t(pxx_reg, t1_reg);
            dyy_reg <= mul_t(pyy_reg, t1_reg);
            dzz_reg <= mul_t(pzz_reg, t1_reg);
            dxy_reg <= mul_t(pxy_reg, t1_reg);
            dxz_reg <= mul_t(pxz_reg, t1_reg);
            dyz_reg <= mul_t(pyz_reg, t1_reg);
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
            sz2_reg <= sz1_reg;
            c2_reg  <= c1_reg;

            for (int e = 0; e < 9; e++)
                m_reg[e] <= m_next[e];
        end
    end

    assign vld  = vld_reg[2];
    assign zero = zero_reg[2];
    assign m00  = m_reg[0];
    assign m01  = m_reg[1];
    assign m02  = m_reg[2];
    assign m10  = m_reg[3];
    assign m11  = m_reg[4];
    assign m12  = m_reg[5];
    assign m20  = m_reg[6];
    assign m21  = m_reg[7];
    assign m22  = m_reg[8];

endmodule

// ===== design/axis_angle_rotation_matrix.sv =====
// A result leaves after its beat passes the sum of squares register, the square root
// and divider chain, then the matrix products and rounding stages.
// Throughput: one beat per cycle; the whole pipe holds while a valid output is stalled.
// Reset clears the valid bits only; the pipe starts empty.
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Axis and angle in, nine entries of the 3x3 rotation matrix out.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix import aarm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [16:0] angle_centideg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22,
    output logic               axis_zero
);

    logic  en;
    logic  n_vld;
    logic  n_zero;
    unit_t ux, uy, uz;
    trig_t c, s;

    // pipe moves unless a finished beat is held at the output
    assign in_stall = out_valid & out_stall;
    assign en       = ~in_stall;

    aarm_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (in_valid),
        .ax     (axis_x),
        .ay     (axis_y),
        .az     (axis_z),
        .vld    (n_vld),
        .zero   (n_zero),
        .ux     (ux),
        .uy     (uy),
        .uz     (uz)
    );

    aarm_trig u_trig (
        .clk   (clk),
        .en    (en),
        .angle (angle_centideg),
        .c     (c),
        .s     (s)
    );

    aarm_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (n_vld),
        .in_zero (n_zero),
        .ux      (ux),
        .uy      (uy),
        .uz      (uz),
        .c       (c),
        .s       (s),
        .vld     (out_valid),
        .zero    (axis_zero),
        .m00     (m00),
        .m01     (m01),
        .m02     (m02),
        .m10     (m10),
        .m11     (m11),
        .m12     (m12),
        .m20     (m20),
        .m21     (m21),
        .m22     (m22)
    );

endmodule

// ===== tb/sv/axis_angle_rotation_matrix_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_check
// Watches both channels, computes the expected rotation matrix of every
// accepted axis/angle beat and compares each output beat against it in order.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_check import aarm_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [16:0] angle_centideg,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m10,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    input  logic               axis_zero,
    output int                 fail_count,
    output int                 pending,
    output int                 matrices_seen
);

    typedef struct {
        logic signed [15:0] m [9];
        logic               zero;
    } matrix_t;

    matrix_t expected_matrices [$];

    localparam longint Q30 = 64'sd1073741824;

    function automatic longint fshift(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint rshift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint lim(input longint v, input longint l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return rshift(a * b, 30);
    endfunction

    function automatic logic signed [15:0] q14(input longint v);
        longint r;
        r = lim(rshift(v, 16), 16384);
        return r[15:0];
    endfunction

    function automatic longint unsigned sqrt64(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_of(input longint a, input longint unsigned nrm);
        longint unsigned mag, q;
        longint u;
        mag = (a < 0) ? -a : a;
        q = ((mag << 46) + nrm / 2) / nrm;
        u = (q > Q30) ? Q30 : q;
        return (a < 0) ? -u : u;
    endfunction

    function automatic longint atan_at(input int i);
        longint tab [24] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};
        return tab[i];
    endfunction

    function automatic matrix_t rotation_of(input longint ax, input longint ay,
                                            input longint az, input longint ang);
        matrix_t res;
        longint unsigned n2, nrm;
        longint ux, uy, uz, r, mm, x, y, z, c, s, t, pxy, pxz, pyz, dx, dy;
        bit cneg, sneg;
        n2 = ax * ax + ay * ay + az * az;
        res.zero = 0;
        if (n2 == 0)
        begin
            for (int i = 0; i < 9; i++) res.m[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
            res.zero = 1;
            return res;
        end
        nrm = sqrt64(n2 << 32);
        ux = unit_of(ax, nrm);
        uy = unit_of(ay, nrm);
        uz = unit_of(az, nrm);
        r = ((ang % 36000) + 36000) % 36000;
        if (r > 18000) r = r - 36000;
        sneg = r < 0;
        mm = sneg ? -r : r;
        cneg = 0;
        if (mm > 9000)
        begin
            mm = 18000 - mm;
            cneg = 1;
        end
        x = 652032874;
        y = 0;
        z = (mm * 191900981 + 512) >>> 10;
        for (int i = 0; i < TRIG_STEPS && i < 24; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_at(i);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_at(i);
            end
        end
        c = lim(x, Q30);
        s = lim(y, Q30);
        if (cneg) c = -c;
        if (sneg) s = -s;
        t = Q30 - c;
        pxy = qmul(qmul(ux, uy), t);
        pxz = qmul(qmul(ux, uz), t);
        pyz = qmul(qmul(uy, uz), t);
        res.m[0] = q14(c + qmul(qmul(ux, ux), t));
        res.m[1] = q14(pxy + qmul(uz, s));
        res.m[2] = q14(pxz - qmul(uy, s));
        res.m[3] = q14(pxy - qmul(uz, s));
        res.m[4] = q14(c + qmul(qmul(uy, uy), t));
        res.m[5] = q14(pyz + qmul(ux, s));
        res.m[6] = q14(pxz + qmul(uy, s));
        res.m[7] = q14(pyz - qmul(ux, s));
        res.m[8] = q14(c + qmul(qmul(uz, uz), t));
        return res;
    endfunction

    assign pending = expected_matrices.size();

    always @(posedge clk)
    begin
        matrix_t want;
        logic signed [15:0] got [9];
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_matrices.push_back(rotation_of(axis_x, axis_y, axis_z,
                                                        angle_centideg));
            if (out_valid && !out_stall)
            begin
                matrices_seen++;
                got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
                if (expected_matrices.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected output beat", $time);
                end
                else
                begin
                    want = expected_matrices.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== want.m[i])
                        begin
                            fail_count++;
                            $display("%0t: entry %0d expected %0d actual %0d",
                                     $time, i, want.m[i], got[i]);
                        end
                    if (axis_zero !== want.zero)
                    begin
                        fail_count++;
                        $display("%0t: axis_zero expected %0b actual %0b",
                                 $time, want.zero, axis_zero);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/axis_angle_rotation_matrix_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_test
// Drives directed and random axis/angle beats with random gaps and output
// stalls, including a long output hold-off, and reports the checker verdict.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_test;

    localparam int RANDOM_BEATS = 1330;
    localparam int IDLE_LIMIT   = 20000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [15:0] axis_x = 0, axis_y = 0, axis_z = 0;
    logic signed [16:0] angle_centideg = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic               axis_zero;
    int                 fail_count, pending, matrices_seen;
    int                 idle_cycles = 0;
    bit                 hold_off = 0;
    bit                 stim_done = 0;

    always #10 clk = ~clk;

    axis_angle_rotation_matrix DUT (.*);

    axis_angle_rotation_matrix_check checker_i (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    task automatic send_beat(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input logic signed [16:0] a,
                             input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        axis_x <= x;
        axis_y <= y;
        axis_z <= z;
        angle_centideg <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic signed [16:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 17'($urandom_range(0, 8) * 4500 - 18000);
            1: return 17'($urandom_range(0, 72000) - 36000);
            2: return $signed(17'($urandom));
            default: return 17'($urandom_range(0, 72000) - 36000);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 4))
            0: return 16'sd0;
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // output stall process; hold_off forces a long stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1;
            else if ($urandom_range(0, 29) == 0)
                out_stall <= 1;
            else if (out_stall && $urandom_range(0, 3) != 0)
                out_stall <= 1;
            else
                out_stall <= 0;
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off || !rst_n)
            idle_cycles <= 0;
        else if (!stim_done || pending != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, zero axis, angle edges
        send_beat(0, 0, 0, 9000, 0);
        send_beat(0, 0, 0, -36000, 0);
        send_beat(16'sh7FFF, 0, 0, 9000, 0);
        send_beat(16'sh8000, 0, 0, -9000, 0);
        send_beat(0, 16'sh7FFF, 0, 18000, 0);
        send_beat(0, 0, 16'sh8000, 36000, 0);
        send_beat(0, 0, 1, 4500, 0);
        send_beat(1, 1, 1, 12000, 0);
        send_beat(-1, -1, -1, -12000, 0);
        send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 17999, 0);
        send_beat(16'sh8000, 16'sh8000, 16'sh8000, -17999, 0);
        send_beat(8192, 0, 0, 0, 0);
        send_beat(0, 8192, 0, 27000, 0);
        send_beat(5000, -3000, 100, 18001, 0);
        send_beat(123, 456, -789, 9001, 0);
        send_beat(-32768, 32767, 0, 65535, 0);
        send_beat(1000, 1000, 0, -65536, 0);
        send_beat(0, -1, 0, 8999, 0);
        send_beat(16'sh5555, 16'shAAAA, 16'sh5555, 17'sh0AAAA, 0);
        send_beat(16'shAAAA, 16'sh5555, 16'shAAAA, 17'sh15555, 0);
        // long output hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 120; i++)
                send_beat(rand_comp(), rand_comp(), rand_comp(), rand_angle(), 0);
        join
        // pause until drained
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        for (int i = 0; i < RANDOM_BEATS - 120; i++)
            send_beat(rand_comp(), rand_comp(), rand_comp(), rand_angle(), 1);
        in_valid <= 0;
        stim_done = 1;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Checked %0d matrices from directed and random axis/angle beats,", matrices_seen);
        $display("with random gaps, output stalls and a long output hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
design/aarm_pkg.sv
design/aarm_norm.sv
design/aarm_trig.sv
design/aarm_matrix.sv
design/axis_angle_rotation_matrix.sv
tb/sv/axis_angle_rotation_matrix_check.sv
tb/sv/axis_angle_rotation_matrix_test.sv
